// File: rtl/core/u8u16_pkg.sv
package u8u16_pkg;

    localparam int UNIT_W = 16;
    localparam int CODE_W = 21;
    localparam int ACC_W  = 31;
    localparam int PEND_W = 3;
    localparam int STAT_W = 3;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QCNT_W-1:0] qcnt_t;

    localparam qptr_t QPTR_LAST = qptr_t'(QDEPTH - 1);
    localparam qcnt_t QCNT_FULL = qcnt_t'(QDEPTH);

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 3'd1;
    localparam logic [STAT_W-1:0] ST_TRUNC   = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNREP   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADLOW  = 3'd4;

    localparam logic [ACC_W-1:0]  CODE_LIMIT = 31'h0011_0000;
    localparam logic [CODE_W-1:0] PLANE1     = 21'h01_0000;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    typedef enum logic [1:0] {
        KIND_UTF16 = 2'd0,
        KIND_UTF8  = 2'd1,
        KIND_ERR   = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic [CODE_W-1:0]   code;
        logic [STAT_W-1:0]   status;
    } job_t;

endpackage

// File: rtl/core/u8u16_front.sv
module u8u16_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clr,
    input  logic                        dir,
    input  logic                        accept,
    input  logic [u8u16_pkg::UNIT_W-1:0] in_unit,
    input  logic                        in_eos,
    output logic                        job_valid,
    output u8u16_pkg::job_t             job
);

    logic [u8u16_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [u8u16_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic                         drop_reg, drop_next;

    logic [u8u16_pkg::ACC_W-1:0]  acc_sh;
    logic [7:0]                   b;
    logic                         err;
    logic                         emit;
    logic [u8u16_pkg::STAT_W-1:0] stat;
    logic [u8u16_pkg::CODE_W-1:0] code;
    u8u16_pkg::job_kind_t         ekind;

    assign b      = in_unit[7:0];
    assign acc_sh = {acc_reg[u8u16_pkg::ACC_W-7:0], b[5:0]};

    always_comb begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        drop_next = drop_reg;
        err       = 1'b0;
        emit      = 1'b0;
        stat      = u8u16_pkg::ST_OK;
        code      = '0;
        ekind     = u8u16_pkg::KIND_UTF16;
        job_valid = 1'b0;
        job.kind   = u8u16_pkg::KIND_UTF16;
        job.code   = '0;
        job.status = u8u16_pkg::ST_OK;

        if (drop_reg) begin
            if (in_eos) begin
                drop_next = 1'b0;
                acc_next  = '0;
                pend_next = '0;
            end
        end else begin
            if (!dir) begin
                ekind = u8u16_pkg::KIND_UTF16;
                if (pend_reg == '0) begin
                    if (b < 8'h80) begin
                        emit = 1'b1;
                        code = {13'd0, b};
                    end else if (b < 8'hc0) begin
                        err  = 1'b1;
                        stat = u8u16_pkg::ST_ILLEGAL;
                    end else if (b < 8'he0) begin
                        acc_next  = {26'd0, b[4:0]};
                        pend_next = 3'd1;
                    end else if (b < 8'hf0) begin
                        acc_next  = {27'd0, b[3:0]};
                        pend_next = 3'd2;
                    end else if (b < 8'hf8) begin
                        acc_next  = {28'd0, b[2:0]};
                        pend_next = 3'd3;
                    end else if (b < 8'hfc) begin
                        acc_next  = {29'd0, b[1:0]};
                        pend_next = 3'd4;
                    end else if (b < 8'hfe) begin
                        acc_next  = {30'd0, b[0]};
                        pend_next = 3'd5;
                    end else begin
                        err  = 1'b1;
                        stat = u8u16_pkg::ST_ILLEGAL;
                    end
                end else begin
                    pend_next = pend_reg - 3'd1;
                    if (pend_reg == 3'd1) begin
                        acc_next = '0;
                        if (acc_sh >= u8u16_pkg::CODE_LIMIT) begin
                            err  = 1'b1;
                            stat = u8u16_pkg::ST_UNREP;
                        end else begin
                            emit = 1'b1;
                            code = acc_sh[u8u16_pkg::CODE_W-1:0];
                        end
                    end else begin
                        acc_next = acc_sh;
                    end
                end
            end else begin
                ekind = u8u16_pkg::KIND_UTF8;
                if (pend_reg != '0) begin
                    if (in_unit[15:10] != u8u16_pkg::LO_SURR_TAG) begin
                        err  = 1'b1;
                        stat = u8u16_pkg::ST_BADLOW;
                    end else begin
                        emit      = 1'b1;
                        code      = {1'b0, acc_reg[9:0], in_unit[9:0]} + u8u16_pkg::PLANE1;
                        acc_next  = '0;
                        pend_next = '0;
                    end
                end else if (in_unit[15:10] == u8u16_pkg::HI_SURR_TAG) begin
                    acc_next  = {15'd0, in_unit};
                    pend_next = 3'd1;
                end else begin
                    emit = 1'b1;
                    code = {5'd0, in_unit};
                end
            end

            if (err) begin
                acc_next  = '0;
                pend_next = '0;
                drop_next = !in_eos;
            end else if (in_eos) begin
                if (pend_next != '0) begin
                    err  = 1'b1;
                    stat = u8u16_pkg::ST_TRUNC;
                end
                acc_next  = '0;
                pend_next = '0;
                drop_next = 1'b0;
            end

            if (err) begin
                job_valid  = 1'b1;
                job.kind   = u8u16_pkg::KIND_ERR;
                job.code   = '0;
                job.status = stat;
            end else if (emit) begin
                job_valid  = 1'b1;
                job.kind   = ekind;
                job.code   = code;
                job.status = u8u16_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            acc_reg  <= '0;
            pend_reg <= '0;
            drop_reg <= 1'b0;
        end else if (accept) begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// File: rtl/core/u8u16_queue.sv
module u8u16_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  u8u16_pkg::job_t  push_job,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output u8u16_pkg::job_t  head_job
);

    u8u16_pkg::job_t  entry_reg [u8u16_pkg::QDEPTH];
    u8u16_pkg::qptr_t wr_ptr_reg, wr_ptr_next;
    u8u16_pkg::qptr_t rd_ptr_reg, rd_ptr_next;
    u8u16_pkg::qcnt_t count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == u8u16_pkg::QCNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == u8u16_pkg::QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == u8u16_pkg::QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next  = count_reg + u8u16_pkg::qcnt_t'(push) - u8u16_pkg::qcnt_t'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/u8u16_back.sv
module u8u16_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  u8u16_pkg::job_t               head_job,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8u16_pkg::UNIT_W-1:0]  m_tdata,
    output logic [u8u16_pkg::STAT_W-1:0]  m_tuser,
    output logic                          m_tlast
);

    logic [1:0]                   idx_reg, idx_next;
    logic                         valid_reg, valid_next;
    logic [u8u16_pkg::UNIT_W-1:0] data_reg;
    logic [u8u16_pkg::STAT_W-1:0] user_reg;
    logic                         last_reg;

    logic [1:0]                   final_idx;
    logic [u8u16_pkg::UNIT_W-1:0] unit;
    logic [19:0]                  sub;
    logic                         load;
    logic [u8u16_pkg::CODE_W-1:0] c;

    assign c   = head_job.code;
    assign sub = 20'(c - u8u16_pkg::PLANE1);

    always_comb begin
        final_idx = 2'd0;
        unit      = '0;
        unique case (head_job.kind)
            u8u16_pkg::KIND_UTF16: begin
                if (c < u8u16_pkg::PLANE1) begin
                    final_idx = 2'd0;
                    unit      = c[15:0];
                end else begin
                    final_idx = 2'd1;
                    unit      = (idx_reg == 2'd0) ? {u8u16_pkg::HI_SURR_TAG, sub[19:10]}
                                                  : {u8u16_pkg::LO_SURR_TAG, c[9:0]};
                end
            end
            u8u16_pkg::KIND_UTF8: begin
                if (c < 21'h80) begin
                    final_idx = 2'd0;
                    unit      = {9'd0, c[6:0]};
                end else if (c < 21'h800) begin
                    final_idx = 2'd1;
                    unit      = (idx_reg == 2'd0) ? {8'd0, 3'b110, c[10:6]}
                                                  : {8'd0, 2'b10, c[5:0]};
                end else if (c < u8u16_pkg::PLANE1) begin
                    final_idx = 2'd2;
                    case (idx_reg)
                        2'd0:    unit = {8'd0, 4'b1110, c[15:12]};
                        2'd1:    unit = {8'd0, 2'b10, c[11:6]};
                        default: unit = {8'd0, 2'b10, c[5:0]};
                    endcase
                end else begin
                    final_idx = 2'd3;
                    case (idx_reg)
                        2'd0:    unit = {8'd0, 5'b11110, c[20:18]};
                        2'd1:    unit = {8'd0, 2'b10, c[17:12]};
                        2'd2:    unit = {8'd0, 2'b10, c[11:6]};
                        default: unit = {8'd0, 2'b10, c[5:0]};
                    endcase
                end
            end
            default: begin
                final_idx = 2'd0;
                unit      = '0;
            end
        endcase
    end

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && (idx_reg == final_idx);

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = pop ? 2'd0 : idx_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= unit;
            user_reg <= head_job.status;
            last_reg <= (idx_reg == final_idx);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// File: rtl/core/utf8_utf16_transcoder.sv
// UTF-8 / UTF-16 stream transcoder.
// Input channel s_*: one source code unit per item in s_tdata (a byte in the low
// eight bits for UTF-8 input), s_tlast marks the last unit of the source.
// Result channel m_*: one produced unit per item in m_tdata, its status in m_tuser
// (0 ok, nonzero error with m_tdata 0), m_tlast on the final result of an input item.
// An input item gives zero to four results; an error gives one status result and
// later input is dropped up to and including the next unit with s_tlast.
// The APB port holds the direction register at address 0 (0: UTF-8 to UTF-16,
// 1: UTF-16 to UTF-8); a write clears the decoder state. Write it only while idle.
// The first result of an item passes a job queue and then the output register
// before m_tvalid shows it. The front classifies one item per cycle while the
// queue is not full; the back emits one result per cycle while m_tready is high.
// A two-entry job queue separates them: when m_tready is low the output register
// holds, the queue fills, and s_tready falls once it is full.
// Reset: direction 0, decoder state cleared, queue and output register empty.
module utf8_utf16_transcoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] in_unit
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_unit
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            dir_reg;
    logic            cfg_wr;
    logic            accept;
    logic            full;
    logic            job_valid;
    u8u16_pkg::job_t job;
    logic            head_valid;
    u8u16_pkg::job_t head_job;
    logic            pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {31'd0, dir_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= 1'b0;
        end else if (cfg_wr) begin
            dir_reg <= pwdata[0];
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    u8u16_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (cfg_wr),
        .dir       (dir_reg),
        .accept    (accept),
        .in_unit   (s_tdata),
        .in_eos    (s_tlast),
        .job_valid (job_valid),
        .job       (job)
    );

    u8u16_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept && job_valid),
        .push_job   (job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u8u16_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: tb/sv/tb.sv
module tb;

    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          HOLD_CYCLES   = 300;
    localparam logic [2:0]  REG_DIRECTION = 3'd0;
    localparam logic        DIR_U8_TO_U16 = 1'b0;
    localparam logic        DIR_U16_TO_U8 = 1'b1;

    typedef struct packed {
        logic [15:0]                  unit;
        logic [u8u16_pkg::STAT_W-1:0] status;
        logic                         last;
    } out_item_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    out_item_t                    expected_units [$];
    out_item_t                    head_item;
    logic                         cfg_dir;
    logic [u8u16_pkg::ACC_W-1:0]  acc_code;
    logic [u8u16_pkg::PEND_W-1:0] pend_units;
    logic                         drop_state;

    int errors      = 0;
    int cycles      = 0;
    int sent_items  = 0;
    int tx_idle_pct = 20;
    int rx_idle_pct = 20;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    utf8_utf16_transcoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic void clear_decoder();
        acc_code   = '0;
        pend_units = '0;
        drop_state = 1'b0;
    endfunction

    function automatic void transcode_unit(input logic [15:0] u, input logic eos);
        logic [7:0]                   b;
        logic [31:0]                  cp;
        logic [31:0]                  c2;
        logic                         have_cp;
        logic [u8u16_pkg::STAT_W-1:0] err;
        int                           len;
        logic [15:0]                  units [$];
        b       = u[7:0];
        cp      = '0;
        have_cp = 1'b0;
        err     = u8u16_pkg::ST_OK;
        if (drop_state) begin
            if (eos)
                clear_decoder();
            return;
        end
        if (cfg_dir == DIR_U8_TO_U16) begin
            if (pend_units == 0) begin
                if (b < 8'h80)      len = 1;
                else if (b < 8'hc0) len = 0;
                else if (b < 8'he0) len = 2;
                else if (b < 8'hf0) len = 3;
                else if (b < 8'hf8) len = 4;
                else if (b < 8'hfc) len = 5;
                else if (b < 8'hfe) len = 6;
                else                len = 0;
                if (len == 0) begin
                    err = u8u16_pkg::ST_ILLEGAL;
                end else if (len == 1) begin
                    cp      = {24'h0, b};
                    have_cp = 1'b1;
                end else begin
                    acc_code   = {23'h0, b & (8'hff >> (len + 1))};
                    pend_units = 3'(len - 1);
                end
            end else begin
                acc_code   = {acc_code[24:0], b[5:0]};
                pend_units = pend_units - 1'b1;
                if (pend_units == 0) begin
                    cp       = {1'b0, acc_code};
                    acc_code = '0;
                    if (cp >= 32'h0011_0000)
                        err = u8u16_pkg::ST_UNREP;
                    else
                        have_cp = 1'b1;
                end
            end
        end else begin
            if (pend_units != 0) begin
                if (u[15:10] != u8u16_pkg::LO_SURR_TAG) begin
                    err = u8u16_pkg::ST_BADLOW;
                end else begin
                    cp         = {12'h0, acc_code[9:0], u[9:0]} + 32'h0001_0000;
                    acc_code   = '0;
                    pend_units = '0;
                    have_cp    = 1'b1;
                end
            end else if (u[15:10] == u8u16_pkg::HI_SURR_TAG) begin
                acc_code   = {15'h0, u};
                pend_units = 1;
            end else begin
                cp      = {16'h0, u};
                have_cp = 1'b1;
            end
        end
        if (err == u8u16_pkg::ST_OK && eos) begin
            if (pend_units != 0)
                err = u8u16_pkg::ST_TRUNC;
            else
                clear_decoder();
        end
        if (err != u8u16_pkg::ST_OK) begin
            expected_units.push_back('{unit: 16'h0000, status: err, last: 1'b1});
            acc_code   = '0;
            pend_units = '0;
            drop_state = !eos;
            return;
        end
        if (have_cp) begin
            if (cfg_dir == DIR_U8_TO_U16) begin
                if (cp < 32'h0001_0000) begin
                    units.push_back(cp[15:0]);
                end else begin
                    c2 = cp - 32'h0001_0000;
                    units.push_back(16'hd800 + {6'h0, c2[19:10]});
                    units.push_back(16'hdc00 + {6'h0, c2[9:0]});
                end
            end else begin
                if (cp < 32'h80) begin
                    units.push_back({8'h00, cp[7:0]});
                end else if (cp < 32'h800) begin
                    units.push_back({8'h00, 3'b110, cp[10:6]});
                    units.push_back({8'h00, 2'b10, cp[5:0]});
                end else if (cp < 32'h0001_0000) begin
                    units.push_back({8'h00, 4'b1110, cp[15:12]});
                    units.push_back({8'h00, 2'b10, cp[11:6]});
                    units.push_back({8'h00, 2'b10, cp[5:0]});
                end else begin
                    units.push_back({8'h00, 5'b11110, cp[20:18]});
                    units.push_back({8'h00, 2'b10, cp[17:12]});
                    units.push_back({8'h00, 2'b10, cp[11:6]});
                    units.push_back({8'h00, 2'b10, cp[5:0]});
                end
            end
        end
        foreach (units[i])
            expected_units.push_back('{unit: units[i], status: u8u16_pkg::ST_OK,
                                       last: (i == units.size() - 1)});
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_units.size() == 0) begin
                    if (errors < 50)
                        $display("%0t: unexpected item: expected none,", $time,
                                 " got unit %h status %0d last %b",
                                 m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    head_item = expected_units.pop_front();
                    if (m_tdata !== head_item.unit || m_tuser !== head_item.status ||
                        m_tlast !== head_item.last) begin
                        if (errors < 50)
                            $display("%0t: mismatch: expected unit %h status %0d last %b,",
                                     $time, head_item.unit, head_item.status,
                                     head_item.last,
                                     " got unit %h status %0d last %b",
                                     m_tdata, m_tuser, m_tlast);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                transcode_unit(s_tdata, s_tlast);
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_unit(input logic [15:0] u, input logic eos);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = u;
        s_tlast  = eos;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_units.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == REG_DIRECTION) begin
            cfg_dir = data[0];
            clear_decoder();
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_direction();
        logic [31:0] rd;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = REG_DIRECTION;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd[0] !== cfg_dir) begin
            $display("%0t: direction readback mismatch: expected %b, got %b",
                     $time, cfg_dir, rd[0]);
            errors++;
        end
    endtask

    task automatic gen_utf8(input int n);
        int          stop;
        int          r;
        int          r2;
        int          len;
        int          cut;
        logic        eos;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] cp;
        logic [7:0]  b;
        stop = sent_items + n;
        while (sent_items < stop) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_unit(16'($urandom), $urandom_range(3) == 0);
            end else begin
                r2 = $urandom_range(99);
                if (r2 < 30)      len = 1;
                else if (r2 < 50) len = 2;
                else if (r2 < 70) len = 3;
                else if (r2 < 90) len = 4;
                else if (r2 < 95) len = 5;
                else              len = 6;
                case (len)
                    1: begin lo = 32'h0;         hi = 32'h7f;       end
                    2: begin lo = 32'h80;        hi = 32'h7ff;      end
                    3: begin lo = 32'h800;       hi = 32'hffff;     end
                    4: begin lo = 32'h1_0000;    hi = 32'h1f_ffff;  end
                    5: begin lo = 32'h20_0000;   hi = 32'h3ff_ffff; end
                    default: begin lo = 32'h400_0000; hi = 32'h7fff_ffff; end
                endcase
                cp  = $urandom_range(hi, lo);
                cut = (r < 15 && len > 1) ? $urandom_range(len - 1, 1) : 0;
                eos = (cut > 0) ? ($urandom_range(1) == 1) : ($urandom_range(7) == 0);
                for (int k = 0; k < len - cut; k++) begin
                    if (k == 0) begin
                        b = (len == 1) ? cp[7:0]
                                       : ((8'hff << (8 - len)) | 8'(cp >> (6 * (len - 1))));
                    end else begin
                        b = 8'h80 | 8'((cp >> (6 * (len - 1 - k))) & 32'h3f);
                        if ($urandom_range(3) == 0)
                            b = b ^ 8'h40;
                    end
                    send_unit({8'($urandom), b}, (k == len - cut - 1) && eos);
                end
            end
        end
    endtask

    task automatic gen_utf16(input int n);
        int          stop;
        int          r;
        logic [15:0] u;
        stop = sent_items + n;
        while (sent_items < stop) begin
            r = $urandom_range(99);
            if (r < 45) begin
                u = 16'($urandom);
                if (u[15:11] == 5'b11011)
                    u[15] = 1'b0;
                send_unit(u, $urandom_range(7) == 0);
            end else if (r < 75) begin
                send_unit(16'hd800 | 16'(10'($urandom)), 1'b0);
                send_unit(16'hdc00 | 16'(10'($urandom)), $urandom_range(7) == 0);
            end else if (r < 85) begin
                send_unit(16'hdc00 | 16'(10'($urandom)), $urandom_range(7) == 0);
            end else if (r < 95) begin
                send_unit(16'hd800 | 16'(10'($urandom)), 1'b0);
                send_unit(16'($urandom), $urandom_range(7) == 0);
            end else begin
                send_unit(16'hd800 | 16'(10'($urandom)), 1'b1);
            end
        end
    endtask

    task automatic test_register();
        check_direction();
        write_reg(REG_DIRECTION, {31'h0, DIR_U16_TO_U8});
        check_direction();
        write_reg(REG_DIRECTION, {31'h0, DIR_U8_TO_U16});
        check_direction();
    endtask

    task automatic test_utf8_directed();
        drain();
        write_reg(REG_DIRECTION, {31'h0, DIR_U8_TO_U16});
        send_unit(16'h0000, 1'b0);
        send_unit(16'hff7f, 1'b0);
        send_unit(16'h00c2, 1'b0);
        send_unit(16'h00a9, 1'b0);
        // highest code point, then one past it
        send_unit(16'h00f4, 1'b0);
        send_unit(16'h008f, 1'b0);
        send_unit(16'h00bf, 1'b0);
        send_unit(16'h00bf, 1'b0);
        send_unit(16'h00f4, 1'b0);
        send_unit(16'h0090, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h0080, 1'b0);
        // drop up to the end of source, then illegal lead, then truncated sequence
        send_unit(16'h0080, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b1);
        send_unit(16'h00fe, 1'b1);
        send_unit(16'h00e2, 1'b0);
        send_unit(16'h0082, 1'b1);
    endtask

    task automatic test_utf16_directed();
        drain();
        write_reg(REG_DIRECTION, {31'h0, DIR_U16_TO_U8});
        send_unit(16'h0041, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'hffff, 1'b0);
        send_unit(16'hd83d, 1'b0);
        send_unit(16'hde00, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hd800, 1'b0);
        send_unit(16'h0041, 1'b0);
        // register write leaves drop mode
        drain();
        write_reg(REG_DIRECTION, {31'h0, DIR_U16_TO_U8});
        send_unit(16'h0800, 1'b0);
        send_unit(16'hdbff, 1'b1);
    endtask

    task automatic test_random_utf8();
        drain();
        write_reg(REG_DIRECTION, {31'h0, DIR_U8_TO_U16});
        gen_utf8(100);
    endtask

    task automatic test_random_utf16();
        drain();
        write_reg(REG_DIRECTION, 32'hffff_ffff);
        check_direction();
        gen_utf16(100);
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(REG_DIRECTION, {31'h0, DIR_U16_TO_U8});
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            if (i % 2 == 1) begin
                send_unit(16'hd800 | 16'(10'($urandom)), 1'b0);
                send_unit(16'hdc00 | 16'(10'($urandom)), 1'b0);
            end else begin
                send_unit(16'($urandom_range(16'hd7ff, 16'h0800)), 1'b0);
            end
        end
        drain();
    endtask

    task automatic test_no_idle();
        drain();
        write_reg(REG_DIRECTION, 32'hffff_fffe);
        check_direction();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        gen_utf8(40);
        drain();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_dir  = DIR_U8_TO_U16;
        clear_decoder();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_register();
        test_utf8_directed();
        test_utf16_directed();
        test_random_utf8();
        test_random_utf16();
        test_backpressure();
        test_no_idle();

        drain();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
